FILE: hw/rtl/ttceb_pkg.sv
// Shared types, constants and the cosine table function for the
// time-to-collision emergency brake. No dependencies.
package ttceb_pkg;

  // Cosine table size over one full turn
  localparam int COS_TABLE_DEPTH = 1024;

  // Angle units: 2^-13 rad, one turn rounded to 51472 units
  localparam int TURN_UNITS = 51472;
  localparam int TURN_HALF  = 25736;

  // Reciprocal of the turn length, scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 32;
  localparam int REM_W       = 17;

  // Divider: one quotient bit per step, 16-bit result
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int DEN_W     = 30;
  localparam int RANGE_K_W = 26;
  localparam int MS_PER_S  = 1000;

  localparam logic [15:0]        TTC_NONE        = 16'hFFFF;
  localparam logic [15:0]        THRESHOLD_RST   = 16'd500;
  localparam logic signed [15:0] ANGLE_START_RST = -16'sd19302;
  localparam logic signed [15:0] ANGLE_STEP_RST  = 16'sd36;

  // Q30 constants for the table build
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_ANGLE_START = 2'd1,
    CFG_ANGLE_STEP  = 2'd2
  } cfg_addr_t;

  typedef struct packed {
    logic              op;
    logic signed [15:0] speed_mm_s;
    logic [15:0]       range_mm;
    logic              range_valid;
    logic              last_beam;
  } in_item_t;

  typedef struct packed {
    logic        brake;
    logic [15:0] min_ttc_ms;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RECIP,
    S_QMUL,
    S_INDEX,
    S_ROM,
    S_CLOSE,
    S_PREP,
    S_DIV,
    S_UPDATE,
    S_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_speed;
    logic capture;
    logic recip;
    logic qmul;
    logic index;
    logic rom;
    logic close;
    logic prep;
    logic div_step;
    logic update;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_needed;
    logic last;
  } status_t;

  // Table entry in signed Q1.14 for an angle given in Q30 radians over
  // one full turn, built at elaboration
  function automatic logic signed [15:0] cos_entry(input longint theta);
    longint th;
    longint x2;
    longint t;
    longint c;
    logic   neg;
    th  = theta;
    neg = 1'b0;
    if (th > Q30_PI) begin
      th = Q30_TWO_PI - th;
    end
    if (th > Q30_HALF_PI) begin
      th  = Q30_PI - th;
      neg = 1'b1;
    end
    if (th < 0) begin
      th = 0;
    end
    // Horner-form series on the folded angle, terms 14*13 down to 2*1
    x2 = (th * th) / Q30_ONE;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd182;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd132;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd90;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd56;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd30;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd12;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 64'sd2;
    if (t < 0) begin
      t = 0;
    end
    c = (t + 64'sd32768) / 64'sd65536;
    return 16'(neg ? -c : c);
  endfunction

endpackage

FILE: hw/rtl/ttceb_dp.sv
// Datapath of the emergency brake: configuration registers, angle to table
// index, cosine table, closing speed, restoring divider and scan minimum.
// Depends on ttceb_pkg.
module ttceb_dp #(
  parameter int COS_TABLE_DEPTH = ttceb_pkg::COS_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  ttceb_pkg::in_item_t  in_data,
  input  ttceb_pkg::cmd_t      cmd,
  output ttceb_pkg::status_t   status,
  output ttceb_pkg::out_item_t out_data
);

  localparam int     AW    = $clog2(COS_TABLE_DEPTH);
  localparam longint N_MAX = longint'(ttceb_pkg::TURN_UNITS - 1) * COS_TABLE_DEPTH
                             + ttceb_pkg::TURN_HALF;
  localparam int     NW    = $clog2(N_MAX + 1);
  localparam longint RECIP = (64'sd1 <<< ttceb_pkg::RECIP_SHIFT) / ttceb_pkg::TURN_UNITS;
  localparam int     RW    = $clog2(RECIP + 1);
  localparam int     PW    = NW + RW;
  localparam int     QW    = PW - ttceb_pkg::RECIP_SHIFT;
  localparam int     RMW   = ttceb_pkg::REM_W;
  localparam int     DW    = ttceb_pkg::DEN_W;
  localparam int     KW    = ttceb_pkg::RANGE_K_W;

  // Cosine table, one constant per entry
  logic signed [15:0] cos_lut [COS_TABLE_DEPTH];

  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_lut
    localparam longint ThetaQ30 = (ttceb_pkg::Q30_TWO_PI * longint'(g)) / COS_TABLE_DEPTH;
    localparam logic signed [15:0] CosVal = ttceb_pkg::cos_entry(ThetaQ30);
    assign cos_lut[g] = CosVal;
  end

  // Configuration and scan state
  logic [15:0]        thr_r,   thr_nxt;
  logic signed [15:0] start_r, start_nxt;
  logic signed [15:0] step_r,  step_nxt;
  logic signed [15:0] speed_r, speed_nxt;
  logic signed [15:0] angle_r, angle_nxt;
  logic [15:0]        min_r,   min_nxt;

  // Per-beam working registers
  logic [KW-1:0]      range_k_r, range_k_nxt;
  logic               valid_r,   valid_nxt;
  logic               last_r,    last_nxt;
  logic [NW-1:0]      n_r,       n_nxt;
  logic [PW-1:0]      p_r,       p_nxt;
  logic [RMW-1:0]     r_r,       r_nxt;
  logic [AW-1:0]      idx_r,     idx_nxt;
  logic signed [15:0] cos_r,     cos_nxt;
  logic signed [31:0] closing_r, closing_nxt;
  logic               use_r,     use_nxt;
  logic               sat_r,     sat_nxt;
  logic [DW-1:0]      rem_r,     rem_nxt;
  logic [15:0]        lo_r,      lo_nxt;
  ttceb_pkg::out_item_t out_r,   out_nxt;

  logic signed [16:0] angle_sum;
  logic [15:0]        angle_mod;
  logic [QW-1:0]      q_est;
  logic [QW-1:0]      q_fix;
  logic [QW+15:0]     q_prod;
  logic [DW-1:0]      den;
  logic               use_now;
  logic               sat_now;
  logic [DW:0]        trial;
  logic               trial_ge;
  logic [15:0]        ttc;

  // Reduce the angle into one turn
  assign angle_sum = 17'(angle_r) + 17'(ttceb_pkg::TURN_UNITS);
  assign angle_mod = angle_r[15] ? angle_sum[15:0] : angle_r;

  // Quotient estimate by reciprocal, low by at most one
  assign q_est  = p_r[PW-1:ttceb_pkg::RECIP_SHIFT];
  assign q_prod = (QW+16)'(q_est) * (QW+16)'(ttceb_pkg::TURN_UNITS);
  assign q_fix  = q_est + QW'(r_r >= RMW'(ttceb_pkg::TURN_UNITS));

  // Divider operands
  assign den      = closing_r[DW-1:0];
  assign use_now  = valid_r && (closing_r > 32'sd0);
  assign sat_now  = {(32 - KW)'(0), range_k_r} >= {den, 2'b00};
  assign trial    = {rem_r, lo_r[15]};
  assign trial_ge = trial >= {1'b0, den};
  assign ttc      = sat_r ? ttceb_pkg::TTC_NONE : lo_r;

  always_comb begin
    thr_nxt     = thr_r;
    start_nxt   = start_r;
    step_nxt    = step_r;
    speed_nxt   = speed_r;
    angle_nxt   = angle_r;
    min_nxt     = min_r;
    range_k_nxt = range_k_r;
    valid_nxt   = valid_r;
    last_nxt    = last_r;
    n_nxt       = n_r;
    p_nxt       = p_r;
    r_nxt       = r_r;
    idx_nxt     = idx_r;
    cos_nxt     = cos_r;
    closing_nxt = closing_r;
    use_nxt     = use_r;
    sat_nxt     = sat_r;
    rem_nxt     = rem_r;
    lo_nxt      = lo_r;
    out_nxt     = out_r;

    // Register writes; unknown indexes drop
    if (cfg_we) begin
      case (cfg_addr)
        ttceb_pkg::CFG_THRESHOLD:   thr_nxt   = cfg_wdata;
        ttceb_pkg::CFG_ANGLE_START: start_nxt = cfg_wdata;
        ttceb_pkg::CFG_ANGLE_STEP:  step_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    if (cmd.load_speed) begin
      speed_nxt = in_data.speed_mm_s;
    end

    // Capture the beam request and start the index computation
    if (cmd.capture) begin
      range_k_nxt = KW'(in_data.range_mm) * KW'(ttceb_pkg::MS_PER_S);
      valid_nxt   = in_data.range_valid;
      last_nxt    = in_data.last_beam;
      n_nxt       = NW'(angle_mod) * NW'(COS_TABLE_DEPTH) + NW'(ttceb_pkg::TURN_HALF);
    end

    if (cmd.recip) begin
      p_nxt = PW'(n_r) * PW'(RECIP);
    end

    if (cmd.qmul) begin
      r_nxt = RMW'(n_r - NW'(q_prod));
    end

    // Round-up index wraps to entry zero
    if (cmd.index) begin
      idx_nxt = (q_fix >= QW'(COS_TABLE_DEPTH)) ? '0 : AW'(q_fix);
    end

    if (cmd.rom) begin
      cos_nxt = cos_lut[idx_r];
    end

    if (cmd.close) begin
      closing_nxt = speed_r * cos_r;
    end

    // Load the divider: high bits of range*1000*2^14 as partial remainder
    if (cmd.prep) begin
      use_nxt = use_now;
      sat_nxt = sat_now;
      rem_nxt = DW'(range_k_r[KW-1:2]);
      lo_nxt  = {range_k_r[1:0], 14'd0};
    end

    // One restoring step, quotient bit shifts into the low word
    if (cmd.div_step) begin
      rem_nxt = trial_ge ? DW'(trial - {1'b0, den}) : DW'(trial);
      lo_nxt  = {lo_r[14:0], trial_ge};
    end

    // Fold the beam into the scan minimum and advance the angle
    if (cmd.update) begin
      if (use_r && (ttc < min_r)) begin
        min_nxt = ttc;
      end
      angle_nxt = angle_r + step_r;
    end

    // Publish the scan result and rearm
    if (cmd.emit) begin
      out_nxt.brake      = min_r < thr_r;
      out_nxt.min_ttc_ms = min_r;
      min_nxt            = ttceb_pkg::TTC_NONE;
      angle_nxt          = start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= ttceb_pkg::THRESHOLD_RST;
      start_r <= ttceb_pkg::ANGLE_START_RST;
      step_r  <= ttceb_pkg::ANGLE_STEP_RST;
      speed_r <= '0;
      angle_r <= ttceb_pkg::ANGLE_START_RST;
      min_r   <= ttceb_pkg::TTC_NONE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      use_r   <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      thr_r   <= thr_nxt;
      start_r <= start_nxt;
      step_r  <= step_nxt;
      speed_r <= speed_nxt;
      angle_r <= angle_nxt;
      min_r   <= min_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      use_r   <= use_nxt;
      sat_r   <= sat_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    range_k_r <= range_k_nxt;
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    r_r       <= r_nxt;
    idx_r     <= idx_nxt;
    cos_r     <= cos_nxt;
    closing_r <= closing_nxt;
    rem_r     <= rem_nxt;
    lo_r      <= lo_nxt;
    out_r     <= out_nxt;
  end

  assign status.div_needed = use_now && !sat_now;
  assign status.last       = last_r;
  assign out_data          = out_r;

`ifndef SYNTHESIS
  // Divider left a proper remainder when its quotient is used
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && use_r && !sat_r |-> rem_r < den)
    else $error("divider remainder not below closing speed");

  // Scan minimum only falls until the scan is published
  a_min_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.emit |=> min_r <= $past(min_r))
    else $error("scan minimum rose inside a scan");
`endif

endmodule

FILE: hw/rtl/ttceb_ctrl.sv
// Controller of the emergency brake: sequences one request through the
// datapath and owns the channel handshakes. Depends on ttceb_pkg.
module ttceb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ttceb_pkg::status_t status,
  output ttceb_pkg::cmd_t    cmd
);

  ttceb_pkg::state_t             state_r, state_nxt;
  logic [ttceb_pkg::CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // State register, divider step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttceb_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ttceb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op) begin
            cmd.capture = 1'b1;
            state_nxt   = ttceb_pkg::S_RECIP;
          end else begin
            cmd.load_speed = 1'b1;
          end
        end
      end
      ttceb_pkg::S_RECIP: begin
        cmd.recip = 1'b1;
        state_nxt = ttceb_pkg::S_QMUL;
      end
      ttceb_pkg::S_QMUL: begin
        cmd.qmul  = 1'b1;
        state_nxt = ttceb_pkg::S_INDEX;
      end
      ttceb_pkg::S_INDEX: begin
        cmd.index = 1'b1;
        state_nxt = ttceb_pkg::S_ROM;
      end
      ttceb_pkg::S_ROM: begin
        cmd.rom   = 1'b1;
        state_nxt = ttceb_pkg::S_CLOSE;
      end
      ttceb_pkg::S_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = ttceb_pkg::S_PREP;
      end
      ttceb_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = status.div_needed ? ttceb_pkg::S_DIV : ttceb_pkg::S_UPDATE;
      end
      ttceb_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ttceb_pkg::CNT_W'(ttceb_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ttceb_pkg::S_UPDATE;
        end
      end
      ttceb_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.last ? ttceb_pkg::S_EMIT : ttceb_pkg::S_IDLE;
      end
      ttceb_pkg::S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ttceb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ttceb_pkg::S_IDLE;
      end
    endcase
  end

  // Output valid: set on publish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // Beam request starts the index sequence next cycle
  a_beam_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> state_r == ttceb_pkg::S_RECIP)
    else $error("beam request did not start the sequence");

  // Publishing never overwrites an untaken result
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result published over a pending result");

  // A result appears only after a publish command
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output valid rose without publish");

  // Divider count moves only while dividing
  a_cnt_div: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> state_r == ttceb_pkg::S_DIV)
    else $error("divider count active outside division");
`endif

endmodule

FILE: hw/rtl/ttc_emergency_brake_top.sv
// Top level of the time-to-collision emergency brake: controller plus
// datapath. Depends on ttceb_pkg, ttceb_ctrl and ttceb_dp.
//
//  channel | ports                              | moves
//  --------+------------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data        | odometry or lidar beam request
//  result  | out_valid, out_ready, out_data     | brake flag and scan minimum
//  config  | cfg_we, cfg_addr, cfg_wdata        | threshold, start angle, step
//
// An odometry request is taken in idle. A beam request runs the reciprocal,
// quotient, index, table, closing and load states, then the 16-step restoring
// divider (skipped for an unused or saturated beam) and the update, taking no
// new request meanwhile. A last beam then publishes when the output is free.
// Reset is synchronous, active low; no clearing pass is needed.
module ttc_emergency_brake_top #(
  parameter int COS_TABLE_DEPTH = ttceb_pkg::COS_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttceb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttceb_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata
);

  ttceb_pkg::cmd_t    cmd;
  ttceb_pkg::status_t status;

  // Sequencer
  ttceb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state
  ttceb_dp #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

FILE: verif/ttceb_tb_pkg.sv
// Item kinds and the unused register index shared by the brake testbench
// files. Depends on nothing.
package ttceb_tb_pkg;

  // Item kind carried in the op field
  localparam logic OP_ODOM = 1'b0;
  localparam logic OP_BEAM = 1'b1;

  // Register index with no register behind it
  localparam logic [1:0] CFG_NO_REG = 2'd3;

endpackage

FILE: verif/ttc_emergency_brake_checker.sv
// Scoreboard for the time-to-collision brake: mirrors the register writes,
// predicts each scan result and compares it with the result channel.
// Depends on ttceb_pkg and ttceb_tb_pkg.
module ttc_emergency_brake_checker
  import ttceb_pkg::*;
  import ttceb_tb_pkg::*;
#(
  parameter int COS_DEPTH = ttceb_pkg::COS_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  // Cosine table in Q1.14, one full turn
  int cos_rom_q14 [COS_DEPTH];

  // Mirrored registers and scan state
  logic [15:0]        thr_ms;
  logic [15:0]        start_angle;
  logic [15:0]        step_angle;
  logic signed [15:0] fwd_speed;
  logic [15:0]        cur_angle;
  logic [15:0]        scan_min;

  // Scan results still to come out of the block
  out_item_t scan_results_q [$];

  // Build cos(2*pi*idx/depth) from a Horner series on the folded angle
  function automatic int cos_q14_at(input int idx);
    longint theta;
    longint sq;
    longint acc;
    longint divisor;
    longint mag;
    bit     flip;
    theta = (Q30_TWO_PI * longint'(idx)) / longint'(COS_DEPTH);
    flip  = 1'b0;
    if (theta > Q30_PI) begin
      theta = Q30_TWO_PI - theta;
    end
    if (theta > Q30_HALF_PI) begin
      theta = Q30_PI - theta;
      flip  = 1'b1;
    end
    if (theta < 0) begin
      theta = 0;
    end
    sq  = (theta * theta) / Q30_ONE;
    acc = Q30_ONE;
    for (int k = 7; k >= 1; k--) begin
      divisor = longint'(2 * k) * longint'(2 * k - 1);
      acc     = Q30_ONE - ((sq * acc) / Q30_ONE) / divisor;
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = (acc + 64'sd32768) / 64'sd65536;
    return flip ? -int'(mag) : int'(mag);
  endfunction

  // Reduce the angle into one turn and round to the nearest table entry
  function automatic int angle_entry(input logic [15:0] ang);
    int     s;
    longint m;
    longint e;
    s = int'($signed(ang));
    m = longint'(((s % TURN_UNITS) + TURN_UNITS) % TURN_UNITS);
    e = (m * longint'(COS_DEPTH) + longint'(TURN_HALF)) / longint'(TURN_UNITS);
    if (e >= longint'(COS_DEPTH)) begin
      e = 0;
    end
    return int'(e);
  endfunction

  // Time to collision of one beam; no closing gives the empty value
  function automatic logic [15:0] beam_ttc(input logic signed [15:0] spd,
                                           input logic [15:0] ang,
                                           input logic [15:0] rng);
    longint closing;
    longint q;
    closing = longint'(spd) * longint'(cos_rom_q14[angle_entry(ang)]);
    if (closing <= 0) begin
      return TTC_NONE;
    end
    q = (longint'(rng) * longint'(MS_PER_S) * 64'sd16384) / closing;
    return (q > 64'sd65535) ? TTC_NONE : 16'(q);
  endfunction

  initial begin
    for (int i = 0; i < COS_DEPTH; i++) begin
      cos_rom_q14[i] = cos_q14_at(i);
    end
  end

  always @(posedge clk) begin : watch
    out_item_t   want;
    logic [15:0] ttc;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      thr_ms      = THRESHOLD_RST;
      start_angle = ANGLE_START_RST;
      step_angle  = ANGLE_STEP_RST;
      fwd_speed   = '0;
      cur_angle   = ANGLE_START_RST;
      scan_min    = TTC_NONE;
      scan_results_q.delete();
    end else begin
      // Mirror register writes; the unused index is dropped
      if (cfg_we) begin
        case (cfg_addr)
          CFG_THRESHOLD:   thr_ms      = cfg_wdata;
          CFG_ANGLE_START: start_angle = cfg_wdata;
          CFG_ANGLE_STEP:  step_angle  = cfg_wdata;
          default: ;
        endcase
      end

      // Compare a taken result with the oldest prediction
      if (out_valid && out_ready) begin
        if (scan_results_q.size() == 0) begin
          $error("result with no scan pending: brake %0b min_ttc_ms %0d",
                 out_data.brake, out_data.min_ttc_ms);
          errs++;
        end else begin
          want = scan_results_q.pop_front();
          if (out_data.brake !== want.brake) begin
            $error("brake: expected %0b, got %0b", want.brake, out_data.brake);
            errs++;
          end
          if (out_data.min_ttc_ms !== want.min_ttc_ms) begin
            $error("min_ttc_ms: expected %0d, got %0d",
                   want.min_ttc_ms, out_data.min_ttc_ms);
            errs++;
          end
        end
      end

      // Advance the scan on each accepted request
      if (in_valid && in_ready) begin
        if (in_data.op == OP_ODOM) begin
          fwd_speed = in_data.speed_mm_s;
        end else begin
          if (in_data.range_valid) begin
            ttc = beam_ttc(fwd_speed, cur_angle, in_data.range_mm);
            if (ttc < scan_min) begin
              scan_min = ttc;
            end
          end
          cur_angle = cur_angle + step_angle;
          if (in_data.last_beam) begin
            want.brake      = (scan_min < thr_ms);
            want.min_ttc_ms = scan_min;
            scan_results_q.push_back(want);
            scan_min  = TTC_NONE;
            cur_angle = start_angle;
          end
        end
      end
    end
    // Count this cycle's mismatches in one update
    if (errs != 0) begin
      fail_count <= fail_count + errs;
    end
    pending <= scan_results_q.size();
  end

endmodule

FILE: verif/tb_ttc_emergency_brake_top.sv
// Testbench top for the time-to-collision brake: clock, reset, request and
// register stimulus, result back-pressure and the verdict. Depends on
// ttceb_pkg, ttceb_tb_pkg, ttc_emergency_brake_top and the checker.
module tb_ttc_emergency_brake_top;
  import ttceb_pkg::*;
  import ttceb_tb_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int DRAIN_CYCLES = 40;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = '0;
  logic [15:0] cfg_wdata = '0;

  int fail_total;
  int pend_results;
  int items_sent  = 0;
  int burst_left  = 5;
  int holds_asked = 0;
  int holds_done  = 0;
  int quiet       = 0;

  ttc_emergency_brake_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ttc_emergency_brake_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_total),
    .pending    (pend_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Odometry request; the unused fields carry random bits
  function automatic in_item_t odo_item(input logic [15:0] spd);
    in_item_t it;
    it.op          = OP_ODOM;
    it.speed_mm_s  = spd;
    it.range_mm    = 16'($urandom);
    it.range_valid = 1'($urandom);
    it.last_beam   = 1'($urandom);
    return it;
  endfunction

  // Beam request; the speed field is ignored and random
  function automatic in_item_t beam_item(input logic [15:0] rng, input logic vld,
                                         input logic lst);
    in_item_t it;
    it.op          = OP_BEAM;
    it.speed_mm_s  = 16'($urandom);
    it.range_mm    = rng;
    it.range_valid = vld;
    it.last_beam   = lst;
    return it;
  endfunction

  // Offer one request, hold it until taken, then maybe end the burst
  task automatic offer(input in_item_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Drop valid, wait for every scan result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus: directed scans, then random phases
  initial begin
    logic [15:0] thr;
    logic [15:0] ang0;
    logic [15:0] stp;
    logic [15:0] spd;
    logic [15:0] rng;
    int          phase;
    int          phase_end;
    int          kind;
    int          n;
    in_item_t    it;
    phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero speed never closes
    offer(odo_item(16'h0000));
    offer(beam_item(16'd1000, 1'b1, 1'b1));
    // Most negative speed closes on the rear-facing start angle
    offer(odo_item(16'h8000));
    offer(beam_item(16'h0000, 1'b1, 1'b0));
    offer(beam_item(16'd100, 1'b0, 1'b0));
    offer(beam_item(16'hFFFF, 1'b1, 1'b1));
    // Largest forward speed moves away at that angle
    offer(odo_item(16'h7FFF));
    offer(beam_item(16'hFFFF, 1'b1, 1'b1));

    // Lowest threshold, straight-ahead beams with no step
    settle();
    write_reg(CFG_THRESHOLD, 16'h0000);
    write_reg(CFG_ANGLE_START, 16'h0000);
    write_reg(CFG_ANGLE_STEP, 16'h0000);
    write_reg(CFG_NO_REG, 16'hBEEF);
    // New start angle applies once this scan closes
    offer(odo_item(16'd1));
    offer(beam_item(16'h0000, 1'b1, 1'b1));
    // Saturated time, then a zero time that still must not brake
    offer(beam_item(16'hFFFF, 1'b1, 1'b0));
    offer(beam_item(16'h0000, 1'b1, 1'b1));

    // Full threshold: an empty scan never brakes, one just below does
    settle();
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    offer(beam_item(16'hFFFF, 1'b1, 1'b1));
    offer(odo_item(16'd1000));
    offer(beam_item(16'd65534, 1'b1, 1'b1));

    // Angle wraps past the signed limit
    settle();
    write_reg(CFG_ANGLE_START, 16'h7FFF);
    write_reg(CFG_ANGLE_STEP, 16'h7FFF);
    offer(beam_item(16'd2000, 1'b1, 1'b0));
    offer(beam_item(16'd3000, 1'b1, 1'b0));
    // Start angle and step change in the middle of a scan
    settle();
    write_reg(CFG_ANGLE_START, 16'h8000);
    write_reg(CFG_ANGLE_STEP, 16'h8000);
    offer(beam_item(16'd4000, 1'b1, 1'b1));
    offer(beam_item(16'd5000, 1'b1, 1'b0));
    offer(beam_item(16'd6000, 1'b1, 1'b1));

    // Random phases, each with its own register setting
    while (items_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 5))
        0:       thr = 16'h0000;
        1:       thr = 16'hFFFF;
        2, 3:    thr = 16'($urandom_range(100, 3000));
        default: thr = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       ang0 = 16'h7FFF;
        1:       ang0 = 16'h8000;
        2, 3:    ang0 = 16'($urandom_range(0, 4000)) - 16'd2000;
        default: ang0 = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       stp = 16'h7FFF;
        1:       stp = 16'h8000;
        2, 3:    stp = 16'($urandom_range(0, 600)) - 16'd300;
        default: stp = 16'($urandom);
      endcase
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_ANGLE_START, ang0);
      write_reg(CFG_ANGLE_STEP, stp);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_NO_REG, 16'($urandom));
      end
      // Ask the receiver for a long hold-off while requests keep coming
      if (phase == 1 || phase == 5) begin
        holds_asked++;
      end
      phase_end = items_sent + $urandom_range(80, 200);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          // Well-formed scan, often after a speed update
          if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
              0:       spd = 16'($urandom);
              1:       spd = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
              default: spd = 16'($urandom_range(200, 15000));
            endcase
            if ($urandom_range(0, 3) == 0) begin
              spd = -spd;
            end
            offer(odo_item(spd));
          end
          n = $urandom_range(1, 10);
          for (int b = 0; b < n; b++) begin
            case ($urandom_range(0, 5))
              0:       rng = 16'($urandom);
              1:       rng = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
              default: rng = 16'($urandom_range(0, 6000));
            endcase
            offer(beam_item(rng, ($urandom_range(0, 7) != 0), (b == n - 1)));
          end
        end else if (kind == 8) begin
          // Noise: any kind, any content
          it    = beam_item(16'($urandom), 1'($urandom), 1'($urandom));
          it.op = 1'($urandom);
          offer(it);
        end else begin
          // Broken scan: beams with no closing beam, merged into the next
          n = $urandom_range(1, 5);
          repeat (n) offer(beam_item(16'($urandom_range(0, 6000)), 1'($urandom), 1'b0));
        end
      end
      phase++;
    end

    // Drain and give the verdict
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_total == 0) begin
      $display("** ttc_emergency_brake_top: PASSED **");
    end else begin
      $display("** ttc_emergency_brake_top: FAILED **");
    end
    $finish;
  end

  // Receiver: long hold-offs on request, otherwise changing stall patterns
  initial begin
    int mode;
    int span;
    int c;
    @(posedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
        for (c = 0; c < span; c++) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ((c % 5) < 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("** ttc_emergency_brake_top: FAILED **");
      $finish;
    end
  end

endmodule

FILE: files.f
hw/rtl/ttceb_pkg.sv
hw/rtl/ttceb_dp.sv
hw/rtl/ttceb_ctrl.sv
hw/rtl/ttc_emergency_brake_top.sv
verif/ttceb_tb_pkg.sv
verif/ttc_emergency_brake_checker.sv
verif/tb_ttc_emergency_brake_top.sv
